@@ design/msk_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msk_pkg: shared types and codes of the max stack
// Request codes, status codes, controller states and the command and status
// groups between controller and datapath.
// ----------------------------------------------------------------------------
package msk_pkg;

	localparam logic [2:0] FN_PUSH    = 3'd0;
	localparam logic [2:0] FN_POP     = 3'd1;
	localparam logic [2:0] FN_TOP     = 3'd2;
	localparam logic [2:0] FN_PEEK    = 3'd3;
	localparam logic [2:0] FN_POP_MAX = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SEARCH,
		S_LDMAX,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_FINISH
	} state_t;

	typedef enum logic [1:0] {
		A_TOP,
		A_TOP2,
		A_PTR_DEC,
		A_PTR_INC
	} addr_sel_t;

	typedef enum logic [1:0] {
		P_HOLD,
		P_TOP2,
		P_DEC,
		P_INC
	} ptr_op_t;

	typedef enum logic [1:0] {
		R_ZERO,
		R_VAL,
		R_MAX,
		R_MQ
	} res_sel_t;

	typedef struct packed {
		logic      in_load;
		logic      rd_en;
		addr_sel_t rd_sel;
		logic      wr_push;
		logic      wr_shift;
		logic      cnt_inc;
		logic      cnt_dec;
		ptr_op_t   ptr_op;
		logic      mq_load;
		logic      run_from_mem;
		logic      res_load;
		res_sel_t  res_sel;
		logic [1:0] res_status;
	} cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       empty;
		logic       full;
		logic       top_is_max;
		logic       val_eq_mq;
		logic       ptr_zero;
		logic       ptr_at_last;
		logic       can_load;
	} stat_t;

endpackage
`default_nettype wire

@@ design/msk_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msk_ctrl: request sequencer of the max stack
// Decodes each request and steps the datapath through reads, the search for
// the maximum and the shift that closes the gap.
// ----------------------------------------------------------------------------
module msk_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  wire msk_pkg::stat_t st,
	output msk_pkg::cmd_t   cmd
);
	import msk_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.rd_sel     = A_TOP;
		cmd.ptr_op     = P_HOLD;
		cmd.res_sel    = R_ZERO;
		cmd.res_status = ST_OK;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.in_load = 1'b1;
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = A_TOP;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (st.can_load) begin
					state_d      = S_IDLE;
					cmd.res_load = 1'b1;
					case (st.func)
						FN_PUSH: begin
							if (st.full) begin
								cmd.res_status = ST_FULL;
							end else begin
								cmd.wr_push = 1'b1;
								cmd.cnt_inc = 1'b1;
							end
						end
						FN_POP, FN_TOP, FN_PEEK: begin
							if (st.empty) begin
								cmd.res_status = ST_EMPTY;
							end else begin
								cmd.res_sel = (st.func == FN_PEEK) ? R_MAX : R_VAL;
								cmd.cnt_dec = (st.func == FN_POP);
							end
						end
						FN_POP_MAX: begin
							if (st.empty) begin
								cmd.res_status = ST_EMPTY;
							end else if (st.top_is_max) begin
								cmd.res_sel = R_MAX;
								cmd.cnt_dec = 1'b1;
							end else begin
								cmd.res_load = 1'b0;
								cmd.mq_load  = 1'b1;
								cmd.ptr_op   = P_TOP2;
								cmd.rd_en    = 1'b1;
								cmd.rd_sel   = A_TOP2;
								state_d      = S_SEARCH;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SEARCH: begin
				if (!(st.val_eq_mq || st.ptr_zero)) begin
					cmd.ptr_op = P_DEC;
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = A_PTR_DEC;
				end else if (st.ptr_zero) begin
					state_d = S_SHIFT_RD;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = A_PTR_DEC;
					state_d    = S_LDMAX;
				end
			end
			S_LDMAX: begin
				cmd.run_from_mem = 1'b1;
				state_d          = S_SHIFT_RD;
			end
			S_SHIFT_RD: begin
				if (st.ptr_at_last) begin
					state_d = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = A_PTR_INC;
					state_d    = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.ptr_op   = P_INC;
				state_d      = S_SHIFT_RD;
			end
			S_FINISH: begin
				if (st.can_load) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = R_MQ;
					cmd.cnt_dec  = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ design/msk_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msk_dp: datapath of the max stack
// Value and running-maximum memories, entry count, scan pointer, request
// latch and the result register toward the output channel.
// ----------------------------------------------------------------------------
module msk_dp #(
	parameter int DEPTH = 32
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire  [2:0]        func,
	input  wire  signed [31:0] push_value,
	input  wire msk_pkg::cmd_t cmd,
	output msk_pkg::stat_t    st,
	output logic              out_valid,
	input  wire               out_ready,
	output logic signed [31:0] result_value,
	output logic [1:0]        status
);
	import msk_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic signed [31:0] val_mem [DEPTH];
	logic signed [31:0] max_mem [DEPTH];

	logic [2:0]         func_q;
	logic signed [31:0] push_q;
	logic [CW-1:0]      cnt_q;
	logic [AW-1:0]      ptr_q;
	logic signed [31:0] mq_q;
	logic signed [31:0] run_q;
	logic signed [31:0] val_rd_q;
	logic signed [31:0] max_rd_q;
	logic signed [31:0] res_q;
	logic [1:0]         stat_q;
	logic               out_valid_q;

	logic [CW-1:0]      cnt_m1;
	logic [CW-1:0]      cnt_m2;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic signed [31:0] wr_val;
	logic signed [31:0] wr_max;
	logic signed [31:0] push_max;
	logic signed [31:0] shift_max;
	logic signed [31:0] res_d;
	logic               can_load;

	assign cnt_m1   = cnt_q - CW'(1);
	assign cnt_m2   = cnt_q - CW'(2);
	assign can_load = !out_valid_q || out_ready;

	always_comb begin
		case (cmd.rd_sel)
			A_TOP:     rd_addr = cnt_m1[AW-1:0];
			A_TOP2:    rd_addr = cnt_m2[AW-1:0];
			A_PTR_DEC: rd_addr = ptr_q - AW'(1);
			A_PTR_INC: rd_addr = ptr_q + AW'(1);
			default:   rd_addr = cnt_m1[AW-1:0];
		endcase
	end

	assign push_max  = (cnt_q == '0 || push_q >= max_rd_q) ? push_q : max_rd_q;
	assign shift_max = (ptr_q == '0 || val_rd_q >= run_q) ? val_rd_q : run_q;
	assign wr_addr   = cmd.wr_push ? cnt_q[AW-1:0] : ptr_q;
	assign wr_val    = cmd.wr_push ? push_q : val_rd_q;
	assign wr_max    = cmd.wr_push ? push_max : shift_max;

	always_ff @(posedge clk) begin
		if (cmd.wr_push || cmd.wr_shift) begin
			val_mem[wr_addr] <= wr_val;
			max_mem[wr_addr] <= wr_max;
		end
		if (cmd.rd_en) begin
			val_rd_q <= val_mem[rd_addr];
			max_rd_q <= max_mem[rd_addr];
		end
	end

	always_comb begin
		case (cmd.res_sel)
			R_ZERO:  res_d = '0;
			R_VAL:   res_d = val_rd_q;
			R_MAX:   res_d = max_rd_q;
			R_MQ:    res_d = mq_q;
			default: res_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			func_q <= func;
			push_q <= push_value;
		end
		if (cmd.mq_load) begin
			mq_q <= max_rd_q;
		end
		if (cmd.run_from_mem) begin
			run_q <= max_rd_q;
		end else if (cmd.wr_shift) begin
			run_q <= shift_max;
		end
		case (cmd.ptr_op)
			P_TOP2:  ptr_q <= cnt_m2[AW-1:0];
			P_DEC:   ptr_q <= ptr_q - AW'(1);
			P_INC:   ptr_q <= ptr_q + AW'(1);
			default: ptr_q <= ptr_q;
		endcase
		if (cmd.res_load) begin
			res_q  <= res_d;
			stat_q <= cmd.res_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_m1;
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		st.func        = func_q;
		st.empty       = (cnt_q == '0);
		st.full        = (cnt_q == CW'(DEPTH));
		st.top_is_max  = (val_rd_q == max_rd_q);
		st.val_eq_mq   = (val_rd_q == mq_q);
		st.ptr_zero    = (ptr_q == '0);
		st.ptr_at_last = (CW'(ptr_q) == cnt_m1);
		st.can_load    = can_load;
	end

	assign out_valid    = out_valid_q;
	assign result_value = res_q;
	assign status       = stat_q;

endmodule
`default_nettype wire

@@ design/max_stack_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_stack_core: bounded stack of signed words with running maximum
// Each request on the input channel (func, push_value) is one of push, pop,
// top, peek max or pop max and gives exactly one result (result_value,
// status) on the output channel, in request order.
// Push, pop, top and peek max: the accepting cycle issues the registered
// memory read of the top entry, the next one decides, writes and loads the
// result register once it is free. A new request is accepted only after the
// previous one has loaded its result.
// Pop max loads its result directly when the top entry holds the maximum;
// otherwise it walks down one entry every cycle until it finds the maximum
// copy nearest the top, then shifts each entry above it down, a read state
// and a write state per entry, through the single read and write port of
// each memory.
// Reset empties the stack and the output register; memory contents are not
// cleared, no clearing pass is needed.
// A stalled receiver holds the result register; the next request is still
// accepted, and its result waits in the sequencer until the register frees.
// ----------------------------------------------------------------------------
module max_stack_core #(
	parameter int DEPTH = 32
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire  [2:0]        func,
	input  wire  signed [31:0] push_value,
	output logic              out_valid,
	input  wire               out_ready,
	output logic signed [31:0] result_value,
	output logic [1:0]        status
);
	import msk_pkg::*;

	cmd_t  cmd;
	stat_t st;

	msk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	msk_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.func         (func),
		.push_value   (push_value),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.status       (status)
	);

	a_count_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(st.full && st.empty))
		else $error("stack count both full and empty");

	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sequencer did not start on accepted request");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> result_value == '0)
		else $error("error result carries a nonzero value");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> st.can_load)
		else $error("result loaded over an untaken result");

endmodule
`default_nettype wire
